// ===== rtl/someip_header_parser_defines.svh =====
// Assertion macros shared by the SOME/IP header parser RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef SOMEIP_HEADER_PARSER_DEFINES_SVH
`define SOMEIP_HEADER_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SHP_ASSERT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define SHP_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SHP_ASSERT(name, clk, rstn, ante, cons, msg)
`define SHP_ASSERT_NEXT(name, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== rtl/shp_pkg.sv =====
// Shared types, codes and helper functions of the SOME/IP header parser.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package shp_pkg;

    localparam int unsigned HdrBytes = 16;
    localparam int unsigned HdrIdxW  = $clog2(HdrBytes);
    localparam logic [31:0] LenBias  = 32'd8;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_MALFORMED = 3'd1;
    localparam logic [2:0] ST_TOO_LONG  = 3'd2;
    localparam logic [2:0] ST_PROTOCOL  = 3'd3;
    localparam logic [2:0] ST_INTERFACE = 3'd4;

    localparam int unsigned CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] CFG_MAX_PAYLOAD  = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_PROTOCOL     = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_INTERFACE    = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_TYPE_REQUEST = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_TYPE_RESP    = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_TYPE_NOTIF   = 3'd5;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_PAYLOAD = 3'b010,
        PH_DISCARD = 3'b100
    } phase_t;

    typedef struct packed {
        logic [15:0] max_payload_len;
        logic [7:0]  expected_protocol;
        logic [7:0]  expected_interface;
        logic [7:0]  type_request;
        logic [7:0]  type_response;
        logic [7:0]  type_notification;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] svc_id;
        logic [15:0] mth_id;
        logic [15:0] cli_id;
        logic [15:0] sess_id;
        logic [7:0]  mtype;
        logic [7:0]  ret_code;
        logic [15:0] payload_length;
        logic [7:0]  payload_byte;
        logic [2:0]  status;
        logic        last;
    } result_t;

    // Handshake between the parse core and the output stage.
    typedef struct packed {
        logic emit;
        logic trailing_error;
    } emit_ctl_t;

    function automatic result_t make_error(logic [2:0] code);
        result_t r;
        r        = '0;
        r.kind   = KIND_ERROR;
        r.status = code;
        r.last   = 1'b1;
        return r;
    endfunction

endpackage

// ===== rtl/shp_cfg_regs.sv =====
// Configuration register bank of the SOME/IP header parser.
// Depends on shp_pkg for the register indexes and the cfg_t type.
`timescale 1ns / 1ps

module shp_cfg_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        wr_en,
    input  logic [shp_pkg::CfgIdxW-1:0] wr_index,
    input  logic [15:0]                 wr_data,
    output shp_pkg::cfg_t               cfg
);

    shp_pkg::cfg_t cfg_reg;
    shp_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                shp_pkg::CFG_MAX_PAYLOAD:  cfg_next.max_payload_len    = wr_data;
                shp_pkg::CFG_PROTOCOL:     cfg_next.expected_protocol  = wr_data[7:0];
                shp_pkg::CFG_INTERFACE:    cfg_next.expected_interface = wr_data[7:0];
                shp_pkg::CFG_TYPE_REQUEST: cfg_next.type_request       = wr_data[7:0];
                shp_pkg::CFG_TYPE_RESP:    cfg_next.type_response      = wr_data[7:0];
                shp_pkg::CFG_TYPE_NOTIF:   cfg_next.type_notification  = wr_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_payload_len    <= 16'd1024;
            cfg_reg.expected_protocol  <= 8'd1;
            cfg_reg.expected_interface <= 8'd1;
            cfg_reg.type_request       <= 8'd0;
            cfg_reg.type_response      <= 8'd128;
            cfg_reg.type_notification  <= 8'd2;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/shp_parse_core.sv =====
// Parse state of the SOME/IP header parser: header capture, header checks,
// payload counting and discard. Depends on shp_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "someip_header_parser_defines.svh"

module shp_parse_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_datagram,
    input  shp_pkg::cfg_t        cfg,
    output shp_pkg::result_t     res,
    output shp_pkg::emit_ctl_t   ctl
);

    shp_pkg::phase_t               phase_reg, phase_next;
    logic [shp_pkg::HdrIdxW-1:0]   idx_reg, idx_next;
    logic [15:0]                   remain_reg, remain_next;
    logic [7:0]                    hdr_reg [shp_pkg::HdrBytes];

    logic [31:0] len_field;
    logic [31:0] plen;
    logic [15:0] remain_dec;
    logic [2:0]  code;
    logic        type_ok;

    assign len_field  = {hdr_reg[4], hdr_reg[5], hdr_reg[6], hdr_reg[7]};
    assign plen       = len_field - shp_pkg::LenBias;
    assign remain_dec = remain_reg - 16'd1;
    assign type_ok    = (hdr_reg[14] == cfg.type_request) ||
                        (hdr_reg[14] == cfg.type_response) ||
                        (hdr_reg[14] == cfg.type_notification);

    always_comb begin
        priority if (len_field < shp_pkg::LenBias) begin
            code = shp_pkg::ST_MALFORMED;
        end else if (plen > {16'd0, cfg.max_payload_len}) begin
            code = shp_pkg::ST_TOO_LONG;
        end else if (hdr_reg[12] != cfg.expected_protocol) begin
            code = shp_pkg::ST_PROTOCOL;
        end else if (hdr_reg[13] != cfg.expected_interface) begin
            code = shp_pkg::ST_INTERFACE;
        end else if (!type_ok) begin
            code = shp_pkg::ST_MALFORMED;
        end else if ((plen != 32'd0) && end_of_datagram) begin
            code = shp_pkg::ST_MALFORMED;
        end else begin
            code = shp_pkg::ST_OK;
        end
    end

    always_comb begin
        phase_next         = phase_reg;
        idx_next           = idx_reg;
        remain_next        = remain_reg;
        res                = '0;
        ctl.emit           = 1'b0;
        ctl.trailing_error = 1'b0;
        unique case (phase_reg)
            shp_pkg::PH_HEADER: begin
                if (idx_reg != shp_pkg::HdrIdxW'(shp_pkg::HdrBytes - 1)) begin
                    idx_next = idx_reg + 1'b1;
                    if (end_of_datagram) begin
                        idx_next = '0;
                        res      = shp_pkg::make_error(shp_pkg::ST_MALFORMED);
                        ctl.emit = 1'b1;
                    end
                end else begin
                    idx_next = '0;
                    ctl.emit = 1'b1;
                    if (code != shp_pkg::ST_OK) begin
                        res        = shp_pkg::make_error(code);
                        phase_next = end_of_datagram ? shp_pkg::PH_HEADER
                                                     : shp_pkg::PH_DISCARD;
                    end else begin
                        res.kind           = shp_pkg::KIND_HEADER;
                        res.svc_id         = {hdr_reg[0], hdr_reg[1]};
                        res.mth_id         = {hdr_reg[2], hdr_reg[3]};
                        res.cli_id         = {hdr_reg[8], hdr_reg[9]};
                        res.sess_id        = {hdr_reg[10], hdr_reg[11]};
                        res.mtype          = hdr_reg[14];
                        res.ret_code       = data_byte;
                        res.payload_length = plen[15:0];
                        if (plen == 32'd0) begin
                            res.last   = 1'b1;
                            phase_next = end_of_datagram ? shp_pkg::PH_HEADER
                                                         : shp_pkg::PH_DISCARD;
                        end else begin
                            remain_next = plen[15:0];
                            phase_next  = shp_pkg::PH_PAYLOAD;
                        end
                    end
                end
            end
            shp_pkg::PH_PAYLOAD: begin
                remain_next      = remain_dec;
                res.kind         = shp_pkg::KIND_PAYLOAD;
                res.payload_byte = data_byte;
                ctl.emit         = 1'b1;
                if (remain_dec == 16'd0) begin
                    res.last   = 1'b1;
                    phase_next = end_of_datagram ? shp_pkg::PH_HEADER
                                                 : shp_pkg::PH_DISCARD;
                end else if (end_of_datagram) begin
                    ctl.trailing_error = 1'b1;
                    remain_next        = '0;
                    phase_next         = shp_pkg::PH_HEADER;
                end
            end
            default: begin
                if (end_of_datagram) begin
                    phase_next = shp_pkg::PH_HEADER;
                    idx_next   = '0;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= shp_pkg::PH_HEADER;
            idx_reg    <= '0;
            remain_reg <= '0;
        end else if (advance) begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            remain_reg <= remain_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && (phase_reg == shp_pkg::PH_HEADER)) begin
            hdr_reg[idx_reg] <= data_byte;
        end
    end

    `SHP_ASSERT(a_payload_count, aclk, aresetn, phase_reg == shp_pkg::PH_PAYLOAD, remain_reg != 16'd0, "payload phase entered with nothing left to count")
    `SHP_ASSERT(a_index_payload, aclk, aresetn, phase_reg != shp_pkg::PH_HEADER, idx_reg == '0, "header index not cleared outside header capture")
    `SHP_ASSERT_NEXT(a_split_exit, aclk, aresetn, advance && ctl.trailing_error, phase_reg == shp_pkg::PH_HEADER && remain_reg == 16'd0, "early end of payload did not return to header capture")

endmodule

// ===== rtl/shp_out_stage.sv =====
// Result register of the SOME/IP header parser with a pending slot for the
// malformed status that follows a truncated payload. Depends on shp_pkg and the macros.
`timescale 1ns / 1ps
`include "someip_header_parser_defines.svh"

module shp_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  shp_pkg::result_t   res_in,
    input  shp_pkg::emit_ctl_t ctl,
    output logic               can_accept,
    output logic               m_valid,
    input  logic               m_ready,
    output shp_pkg::result_t   res_out
);

    logic             valid_reg, valid_next;
    logic             pend_reg, pend_next;
    shp_pkg::result_t res_reg, res_next;

    assign can_accept = !pend_reg && (!valid_reg || m_ready);

    always_comb begin
        valid_next = valid_reg;
        pend_next  = pend_reg;
        res_next   = res_reg;
        priority if (load && ctl.emit) begin
            valid_next = 1'b1;
            res_next   = res_in;
            pend_next  = ctl.trailing_error;
        end else if (valid_reg && m_ready) begin
            if (pend_reg) begin
                res_next  = shp_pkg::make_error(shp_pkg::ST_MALFORMED);
                pend_next = 1'b0;
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign m_valid = valid_reg;
    assign res_out = res_reg;

    `SHP_ASSERT(a_pend_valid, aclk, aresetn, pend_reg, valid_reg, "pending status without a result in the register")
    `SHP_ASSERT(a_pend_blocks, aclk, aresetn, pend_reg, !can_accept, "new request taken while a status is pending")
    `SHP_ASSERT_NEXT(a_pend_issue, aclk, aresetn, pend_reg && valid_reg && m_ready, valid_reg && !pend_reg && res_reg.kind == shp_pkg::KIND_ERROR && res_reg.status == shp_pkg::ST_MALFORMED && res_reg.last, "pending malformed status not presented")

endmodule

// ===== rtl/someip_header_parser.sv =====
// Top level of the SOME/IP message header parser: input register, parse core,
// configuration bank and result register. Depends on shp_pkg and the shp_* modules.
`timescale 1ns / 1ps

// The parser takes one datagram byte per cycle while the result register is not
// stalled by m_tready or a pending status, and gives at most one result per cycle;
// an accepted byte is registered in the input register and its result in the result
// register. The input register, the combinational header checks and the result
// register set that rate. A datagram that ends inside its payload yields a payload
// byte followed by a malformed status, so the next byte waits in the input register
// while the second result is presented. There is no clearing pass after reset.
module someip_header_parser (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] data_byte
    input  logic                        s_tlast,   // end_of_datagram
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [15:0] svc_id, [31:16] mth_id, [47:32] cli_id, [63:48] sess_id,
    // [71:64] mtype, [79:72] ret_code, [95:80] payload_length,
    // [103:96] payload_byte, [106:104] status, [111:107] zero
    output logic [111:0]                m_tdata,
    output logic [1:0]                  m_tuser,   // [1:0] kind
    output logic                        m_tlast,   // last
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [shp_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [15:0]                 cfg_data
);

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               in_end_reg;
    logic               advance;
    logic               can_accept;
    shp_pkg::cfg_t      cfg;
    shp_pkg::result_t   core_res;
    shp_pkg::emit_ctl_t core_ctl;
    shp_pkg::result_t   out_res;

    assign advance   = in_valid_reg && can_accept;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
    end

    shp_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    shp_parse_core u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .advance         (advance),
        .data_byte       (in_byte_reg),
        .end_of_datagram (in_end_reg),
        .cfg             (cfg),
        .res             (core_res),
        .ctl             (core_ctl)
    );

    shp_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance),
        .res_in     (core_res),
        .ctl        (core_ctl),
        .can_accept (can_accept),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .res_out    (out_res)
    );

    assign m_tdata = {5'd0,
                      out_res.status,
                      out_res.payload_byte,
                      out_res.payload_length,
                      out_res.ret_code,
                      out_res.mtype,
                      out_res.sess_id,
                      out_res.cli_id,
                      out_res.mth_id,
                      out_res.svc_id};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for someip_header_parser: streams datagram bytes, predicts
// every header, payload and status result in SystemVerilog, and compares them in order.
// Depends on shp_pkg and the someip_header_parser RTL; nothing else.
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_REQUESTS = 320;
    localparam int NO_HOLD = -1;
    localparam logic [shp_pkg::CfgIdxW-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [shp_pkg::CfgIdxW-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [7:0] data;
        logic       eod;
    } req_t;

    logic                         aclk;
    logic                         aresetn = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [7:0]                   s_tdata = '0;
    logic                         s_tlast = 1'b0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [111:0]                 m_tdata;
    logic [1:0]                   m_tuser;
    logic                         m_tlast;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [shp_pkg::CfgIdxW-1:0]  cfg_index = '0;
    logic [15:0]                  cfg_data = '0;

    someip_header_parser u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Parser model state, kept in step with every accepted request.
    shp_pkg::cfg_t   cfg = '{16'd1024, 8'd1, 8'd1, 8'd0, 8'd128, 8'd2};
    shp_pkg::phase_t parse_ph = shp_pkg::PH_HEADER;
    int              hdr_fill = 0;
    logic [7:0]      hdr_buf [16];
    logic [15:0]     pay_left = '0;

    req_t             byte_q [$];
    req_t             frame [$];
    shp_pkg::result_t expected_q [$];
    req_t             cur_req;

    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int sent_cnt = 0;
    int taken_cnt = 0;
    int res_cnt = 0;
    int fail_cnt = 0;
    int cycle_cnt = 0;
    int hdr_seen = 0;
    int pay_seen = 0;
    int err_seen = 0;
    logic in_taken = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic flag_mismatch(string msg);
        $display("MISMATCH: %s", msg);
        fail_cnt++;
    endtask

    task automatic cmp_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            flag_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                    res_cnt, name, got, want));
    endtask

    function automatic void expect_error(logic [2:0] code);
        shp_pkg::result_t r;
        r = '0;
        r.kind = shp_pkg::KIND_ERROR;
        r.status = code;
        r.last = 1'b1;
        expected_q.push_back(r);
    endfunction

    function automatic void expect_payload(logic [7:0] b, logic is_last);
        shp_pkg::result_t r;
        r = '0;
        r.kind = shp_pkg::KIND_PAYLOAD;
        r.payload_byte = b;
        r.last = is_last;
        expected_q.push_back(r);
    endfunction

    function automatic void parse_byte(logic [7:0] b, logic eod);
        shp_pkg::result_t r;
        logic [31:0] len;
        logic [31:0] plen;
        logic [2:0] code;
        logic [7:0] mt;
        case (parse_ph)
            shp_pkg::PH_HEADER: begin
                hdr_buf[4'(hdr_fill)] = b;
                hdr_fill++;
                if (hdr_fill < 16) begin
                    if (eod) begin
                        hdr_fill = 0;
                        expect_error(shp_pkg::ST_MALFORMED);
                    end
                    return;
                end
                hdr_fill = 0;
                len = {hdr_buf[4], hdr_buf[5], hdr_buf[6], hdr_buf[7]};
                mt = hdr_buf[14];
                plen = len - 32'd8;
                code = shp_pkg::ST_OK;
                if (len < 32'd8) code = shp_pkg::ST_MALFORMED;
                else if (plen > {16'd0, cfg.max_payload_len}) code = shp_pkg::ST_TOO_LONG;
                else if (hdr_buf[12] != cfg.expected_protocol) code = shp_pkg::ST_PROTOCOL;
                else if (hdr_buf[13] != cfg.expected_interface) code = shp_pkg::ST_INTERFACE;
                else if (mt != cfg.type_request && mt != cfg.type_response &&
                         mt != cfg.type_notification) code = shp_pkg::ST_MALFORMED;
                if (code == shp_pkg::ST_OK && plen != 0 && eod) code = shp_pkg::ST_MALFORMED;
                if (code != shp_pkg::ST_OK) begin
                    parse_ph = eod ? shp_pkg::PH_HEADER : shp_pkg::PH_DISCARD;
                    expect_error(code);
                    return;
                end
                r = '0;
                r.kind = shp_pkg::KIND_HEADER;
                r.svc_id = {hdr_buf[0], hdr_buf[1]};
                r.mth_id = {hdr_buf[2], hdr_buf[3]};
                r.cli_id = {hdr_buf[8], hdr_buf[9]};
                r.sess_id = {hdr_buf[10], hdr_buf[11]};
                r.mtype = mt;
                r.ret_code = hdr_buf[15];
                r.payload_length = plen[15:0];
                if (plen == 0) begin
                    r.last = 1'b1;
                    parse_ph = eod ? shp_pkg::PH_HEADER : shp_pkg::PH_DISCARD;
                end else begin
                    pay_left = plen[15:0];
                    parse_ph = shp_pkg::PH_PAYLOAD;
                end
                expected_q.push_back(r);
            end
            shp_pkg::PH_PAYLOAD: begin
                pay_left = pay_left - 16'd1;
                if (pay_left == 0) begin
                    expect_payload(b, 1'b1);
                    parse_ph = eod ? shp_pkg::PH_HEADER : shp_pkg::PH_DISCARD;
                end else if (eod) begin
                    expect_payload(b, 1'b0);
                    expect_error(shp_pkg::ST_MALFORMED);
                    pay_left = '0;
                    parse_ph = shp_pkg::PH_HEADER;
                end else begin
                    expect_payload(b, 1'b0);
                end
            end
            default: begin
                if (eod) begin
                    parse_ph = shp_pkg::PH_HEADER;
                    hdr_fill = 0;
                end
            end
        endcase
    endfunction

    task automatic check_result();
        shp_pkg::result_t got;
        shp_pkg::result_t want;
        got.kind = m_tuser;
        got.svc_id = m_tdata[15:0];
        got.mth_id = m_tdata[31:16];
        got.cli_id = m_tdata[47:32];
        got.sess_id = m_tdata[63:48];
        got.mtype = m_tdata[71:64];
        got.ret_code = m_tdata[79:72];
        got.payload_length = m_tdata[95:80];
        got.payload_byte = m_tdata[103:96];
        got.status = m_tdata[106:104];
        got.last = m_tlast;
        res_cnt++;
        if (got.kind == shp_pkg::KIND_HEADER) hdr_seen++;
        else if (got.kind == shp_pkg::KIND_PAYLOAD) pay_seen++;
        else err_seen++;
        if (expected_q.size() == 0) begin
            flag_mismatch($sformatf("result %0d arrived with nothing expected", res_cnt));
            return;
        end
        want = expected_q.pop_front();
        cmp_field("kind", 16'(got.kind), 16'(want.kind));
        cmp_field("svc_id", got.svc_id, want.svc_id);
        cmp_field("mth_id", got.mth_id, want.mth_id);
        cmp_field("cli_id", got.cli_id, want.cli_id);
        cmp_field("sess_id", got.sess_id, want.sess_id);
        cmp_field("mtype", 16'(got.mtype), 16'(want.mtype));
        cmp_field("ret_code", 16'(got.ret_code), 16'(want.ret_code));
        cmp_field("payload_length", got.payload_length, want.payload_length);
        cmp_field("payload_byte", 16'(got.payload_byte), 16'(want.payload_byte));
        cmp_field("status", 16'(got.status), 16'(want.status));
        cmp_field("last", 16'(got.last), 16'(want.last));
    endtask

    // Request driver and result ready, both changed on the falling edge.
    always @(negedge aclk) begin
        if (!s_tvalid || in_taken) begin
            if (byte_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                cur_req = byte_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= cur_req.data;
                s_tlast <= cur_req.eod;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                taken_cnt++;
                parse_byte(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) check_result();
            in_taken <= s_tvalid && s_tready;
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, expected_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic wait_drained();
        while (sent_cnt != taken_cnt || expected_q.size() != 0) @(negedge aclk);
    endtask

    task automatic write_reg(logic [shp_pkg::CfgIdxW-1:0] idx, logic [15:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            shp_pkg::CFG_MAX_PAYLOAD:  cfg.max_payload_len = val;
            shp_pkg::CFG_PROTOCOL:     cfg.expected_protocol = val[7:0];
            shp_pkg::CFG_INTERFACE:    cfg.expected_interface = val[7:0];
            shp_pkg::CFG_TYPE_REQUEST: cfg.type_request = val[7:0];
            shp_pkg::CFG_TYPE_RESP:    cfg.type_response = val[7:0];
            shp_pkg::CFG_TYPE_NOTIF:   cfg.type_notification = val[7:0];
            default: ;
        endcase
    endtask

    task automatic load_config(shp_pkg::cfg_t c, logic touch_spare);
        write_reg(shp_pkg::CFG_MAX_PAYLOAD, c.max_payload_len);
        write_reg(shp_pkg::CFG_PROTOCOL, {8'd0, c.expected_protocol});
        write_reg(shp_pkg::CFG_INTERFACE, {8'd0, c.expected_interface});
        write_reg(shp_pkg::CFG_TYPE_REQUEST, {8'd0, c.type_request});
        write_reg(shp_pkg::CFG_TYPE_RESP, {8'd0, c.type_response});
        write_reg(shp_pkg::CFG_TYPE_NOTIF, {8'd0, c.type_notification});
        if (touch_spare) begin
            write_reg(CFG_SPARE_LO, 16'hFFFF);
            write_reg(CFG_SPARE_HI, 16'h0000);
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic void add_header(input logic [15:0] svc, input logic [15:0] mth,
                                       input logic [31:0] len, input logic [15:0] cli,
                                       input logic [15:0] ses, input logic [7:0] proto,
                                       input logic [7:0] iface, input logic [7:0] mt,
                                       input logic [7:0] rc);
        logic [127:0] h;
        h = {svc, mth, len, cli, ses, proto, iface, mt, rc};
        for (int i = 15; i >= 0; i--) frame.push_back(req_t'{h[i*8 +: 8], 1'b0});
    endfunction

    function automatic void add_bytes(int n);
        for (int i = 0; i < n; i++) frame.push_back(req_t'{8'($urandom), 1'b0});
    endfunction

    // Queues the built frame with the end mark on its final byte; a hold index makes
    // the sender wait there until every outstanding result has come back.
    task automatic ship(int hold_at);
        if (frame.size() == 0) return;
        frame[frame.size() - 1].eod = 1'b1;
        for (int i = 0; i < frame.size(); i++) begin
            if (i == hold_at) wait_drained();
            byte_q.push_back(frame[i]);
            sent_cnt++;
        end
        frame.delete();
    endtask

    function automatic logic [7:0] good_type();
        case ($urandom_range(2))
            0: return cfg.type_request;
            1: return cfg.type_response;
            default: return cfg.type_notification;
        endcase
    endfunction

    // One random datagram. Most are well formed; the rest end early, carry a bad
    // header, trail extra bytes or are plain noise.
    task automatic queue_datagram(output int counted);
        int unsigned sel;
        int unsigned cap;
        int unsigned pl;
        int unsigned extra;
        int unsigned cut;
        logic [31:0] len;
        logic [7:0] proto;
        logic [7:0] iface;
        logic [7:0] mt;
        sel = $urandom_range(99);
        counted = 0;
        extra = 0;
        if (sel >= 93) begin
            repeat ($urandom_range(24, 1))
                frame.push_back(req_t'{8'($urandom), ($urandom_range(7) == 0)});
            ship(NO_HOLD);
            return;
        end
        proto = cfg.expected_protocol;
        iface = cfg.expected_interface;
        mt = good_type();
        cap = ($urandom_range(7) == 0) ? 64 : 16;
        if (cap > 32'(cfg.max_payload_len)) cap = 32'(cfg.max_payload_len);
        pl = $urandom_range(cap, 0);
        if (sel >= 63 && sel < 75 && cfg.max_payload_len >= 2 && pl < 2) pl = 2;
        if (sel >= 63 && sel < 71 && cfg.max_payload_len >= 1000 && $urandom_range(3) == 0)
            pl = 32'(cfg.max_payload_len);
        len = pl + 8;
        if (sel >= 81) begin
            case ($urandom_range(4))
                0: len = $urandom_range(7);
                1: len = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF :
                         {16'd0, cfg.max_payload_len} + 32'd9 + $urandom_range(300);
                2: do proto = 8'($urandom); while (proto == cfg.expected_protocol);
                3: do iface = 8'($urandom); while (iface == cfg.expected_interface);
                default: do mt = 8'($urandom); while (mt == cfg.type_request ||
                                                      mt == cfg.type_response ||
                                                      mt == cfg.type_notification);
            endcase
        end
        add_header(16'($urandom), 16'($urandom), len, 16'($urandom), 16'($urandom),
                   proto, iface, mt, 8'($urandom));
        if (sel < 55) begin
            add_bytes(pl);
        end else if (sel < 63) begin
            add_bytes(pl);
            extra = $urandom_range(6, 1);
            add_bytes(extra);
        end else if (sel < 71) begin
            cut = (pl > 21) ? 20 : pl - 1;
            add_bytes((pl >= 2) ? $urandom_range(cut, 1) : pl);
        end else if (sel < 75) begin
            // ends on the sixteenth byte
        end else if (sel < 81) begin
            frame = frame[0:$urandom_range(14)];
        end else begin
            extra = $urandom_range(5);
            add_bytes(extra);
        end
        counted = frame.size() - extra;
        ship(NO_HOLD);
    endtask

    initial begin
        shp_pkg::cfg_t phase_cfg [4];
        int src_pct [4];
        int snk_pct [4];
        int done_cnt;
        int got_cnt;
        phase_cfg[0] = '{16'hFFFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h7F};
        phase_cfg[1] = '{16'h0000, 8'hFF, 8'h00, 8'h01, 8'h02, 8'h03};
        phase_cfg[2] = '{16'd37, 8'h01, 8'h01, 8'h00, 8'h80, 8'h02};
        phase_cfg[3] = '{16'd1024, 8'h01, 8'h01, 8'h00, 8'h80, 8'h02};
        src_pct = '{0, 83, 0, 25};
        snk_pct = '{0, 0, 83, 25};

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // Directed datagrams under the reset configuration.
        add_header(16'h0000, 16'h0000, 32'd8, 16'h0000, 16'h0000, 8'd1, 8'd1, 8'd0, 8'h00);
        ship(NO_HOLD);
        add_header(16'hFFFF, 16'hFFFF, 32'd10, 16'hFFFF, 16'hFFFF, 8'd1, 8'd1, 8'd128, 8'hFF);
        frame.push_back(req_t'{8'hFF, 1'b0});
        frame.push_back(req_t'{8'h00, 1'b0});
        ship(17);
        add_header(16'h1234, 16'h8001, 32'd9, 16'hA5A5, 16'h5A5A, 8'd1, 8'd1, 8'd2, 8'h01);
        add_bytes(3);
        ship(9);
        add_header(16'h0001, 16'h0002, 32'd7, 16'h0003, 16'h0004, 8'd1, 8'd1, 8'd0, 8'h00);
        add_bytes(3);
        ship(NO_HOLD);
        add_header(16'h0101, 16'h0202, 32'hFFFF_FFFF, 16'h0303, 16'h0404, 8'd1, 8'd1, 8'd0,
                   8'h00);
        ship(NO_HOLD);
        add_header(16'h4444, 16'h5555, 32'd1032, 16'h6666, 16'h7777, 8'd1, 8'd1, 8'd128,
                   8'h00);
        add_bytes(3);
        ship(NO_HOLD);
        add_header(16'h0F0F, 16'hF0F0, 32'd1033, 16'h0000, 16'h0000, 8'd1, 8'd1, 8'd2, 8'h00);
        add_bytes(2);
        ship(NO_HOLD);
        add_header(16'h1111, 16'h2222, 32'd8, 16'h3333, 16'h4444, 8'd0, 8'd1, 8'd0, 8'h00);
        ship(NO_HOLD);
        add_header(16'h1111, 16'h2222, 32'd8, 16'h3333, 16'h4444, 8'd1, 8'hFF, 8'd0, 8'h00);
        add_bytes(1);
        ship(NO_HOLD);
        add_header(16'h1111, 16'h2222, 32'd8, 16'h3333, 16'h4444, 8'd1, 8'd1, 8'd1, 8'h00);
        ship(NO_HOLD);
        add_header(16'hBEEF, 16'h0000, 32'd12, 16'h0000, 16'h0000, 8'd1, 8'd1, 8'd0, 8'h00);
        ship(NO_HOLD);
        add_bytes(1);
        ship(NO_HOLD);
        add_bytes(15);
        ship(9);
        wait_drained();
        repeat (8) @(negedge aclk);

        for (int p = 0; p < 4; p++) begin
            load_config(phase_cfg[p], (p == 2));
            src_idle_pct = src_pct[p];
            snk_stall_pct = snk_pct[p];
            done_cnt = 0;
            while (done_cnt < PHASE_REQUESTS) begin
                queue_datagram(got_cnt);
                done_cnt += got_cnt;
                while (byte_q.size() > 64) @(negedge aclk);
            end
            wait_drained();
            repeat (8) @(negedge aclk);
        end

        if (expected_q.size() != 0)
            flag_mismatch($sformatf("%0d expected results never arrived", expected_q.size()));
        $display("Run covered %0d requests over 4 register settings and 4 idle patterns.",
                 taken_cnt);
        $display("Results checked: %0d headers, %0d payload bytes, %0d status errors.",
                 hdr_seen, pay_seen, err_seen);
        if (fail_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/shp_pkg.sv
rtl/shp_cfg_regs.sv
rtl/shp_parse_core.sv
rtl/shp_out_stage.sv
rtl/someip_header_parser.sv
tb/sv/tb_top.sv
